// File: hw/rtl/xcrfr_pkg.sv
// ----------------------------------------------------------------------------
// xcrfr_pkg
// Types and codes shared by the XOR-checked reply frame receiver.
// ----------------------------------------------------------------------------
package xcrfr_pkg;

	// event kinds on the input stream (tuser)
	localparam logic [1:0] EV_BYTE    = 2'd0;
	localparam logic [1:0] EV_TIMEOUT = 2'd1;
	localparam logic [1:0] EV_CANCEL  = 2'd2;

	// result status codes (tuser)
	localparam logic [2:0] ST_FRAME  = 3'd0;
	localparam logic [2:0] ST_OK     = 3'd1;
	localparam logic [2:0] ST_RETRY  = 3'd2;
	localparam logic [2:0] ST_FAIL   = 3'd3;
	localparam logic [2:0] ST_CANCEL = 3'd4;

	// configuration register indexes
	localparam logic REG_EXPECTED_HEAD = 1'b0;
	localparam logic REG_MAX_ATTEMPTS  = 1'b1;

	localparam logic [7:0] NEG_OFFSET = 8'h80;
	localparam logic [8:0] FRAME_OVERHEAD = 9'd3;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic [2:0] status;
		logic       negative_reply;
		logic [8:0] frame_length;
		logic [1:0] attempt;
	} result_t;

endpackage

// File: hw/rtl/xor_checked_response_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// xor_checked_response_frame_receiver_core
// Hunts for a reply head, echoes frame bytes, checks the XOR check byte
// and tracks timeouts, cancels and retries across attempts.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | tuser event kind, tdata rx byte
//  m_*     | out       | m_tvalid/m_tready  | tdata byte/length/attempt,
//          |           |                    | tuser status/negative, tlast
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled. An item is
// captured in the input register, the frame logic evaluates it and the
// result lands in the output register. A stalled output holds the input
// register; the input side stays ready in any cycle in which the output
// register is free or being drained.
// Asynchronous reset puts the receiver in head hunt with attempts at zero,
// expected head 0 and max attempts 3. Configuration is always ready.
// ----------------------------------------------------------------------------
module xor_checked_response_frame_receiver_core
	import xcrfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] event_kind

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [16:8] frame_length,
	                               // [18:17] attempt, [23:19] zero
	output logic [3:0]  m_tuser,   // [2:0] status, [3] negative_reply
	output logic        m_tlast,   // last

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	// configuration
	logic [7:0] expected_head_q;
	logic [1:0] max_attempts_q;

	// input register
	logic       valid_s1;
	logic [1:0] event_s1;
	logic [7:0] byte_s1;
	logic       advance_s1;

	// frame state
	phase_t     phase_q, phase_d;
	logic [8:0] remaining_q, remaining_d;
	logic [7:0] xor_q, xor_d;
	logic [1:0] attempt_q, attempt_d;
	logic       neg_q, neg_d;
	logic [7:0] len_q, len_d;

	// result
	logic    res_vld;
	result_t res;
	result_t out_q;
	logic    out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_head_q <= 8'h00;
			max_attempts_q  <= 2'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EXPECTED_HEAD: expected_head_q <= cfg_data;
				REG_MAX_ATTEMPTS:  max_attempts_q  <= cfg_data[1:0];
				default:           ;
			endcase
		end
	end

	assign advance_s1 = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			event_s1 <= s_tuser;
			byte_s1  <= s_tdata;
		end
	end

	logic       lost_final;
	logic [2:0] lost_status;
	logic [1:0] lost_attempt;

	always_comb begin
		// attempt ended without success: retry or give up
		lost_final   = ({1'b0, attempt_q} + 3'd1) >= {1'b0, max_attempts_q};
		lost_status  = lost_final ? ST_FAIL : ST_RETRY;
		lost_attempt = lost_final ? 2'd0 : attempt_q + 2'd1;
	end

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		xor_d       = xor_q;
		attempt_d   = attempt_q;
		neg_d       = neg_q;
		len_d       = len_q;

		res_vld            = 1'b0;
		res.out_byte       = 8'h00;
		res.last           = 1'b0;
		res.status         = ST_FRAME;
		res.negative_reply = neg_q;
		res.frame_length   = 9'd0;
		res.attempt        = attempt_q;

		case (event_s1)
			EV_TIMEOUT: begin
				res_vld     = 1'b1;
				res.last    = 1'b1;
				res.status  = lost_status;
				attempt_d   = lost_attempt;
				phase_d     = PH_HUNT;
				remaining_d = 9'd0;
				xor_d       = 8'h00;
				neg_d       = 1'b0;
				len_d       = 8'h00;
			end
			EV_CANCEL: begin
				res_vld     = 1'b1;
				res.last    = 1'b1;
				res.status  = ST_CANCEL;
				attempt_d   = 2'd0;
				phase_d     = PH_HUNT;
				remaining_d = 9'd0;
				xor_d       = 8'h00;
				neg_d       = 1'b0;
				len_d       = 8'h00;
			end
			EV_BYTE: begin
				res.out_byte = byte_s1;
				unique case (phase_q)
					PH_LEN: begin
						res_vld     = 1'b1;
						len_d       = byte_s1;
						xor_d       = xor_q ^ byte_s1;
						remaining_d = {1'b0, byte_s1} + 9'd1;
						phase_d     = PH_BODY;
					end
					PH_BODY: begin
						res_vld = 1'b1;
						if (remaining_q > 9'd1) begin
							remaining_d = remaining_q - 9'd1;
							xor_d       = xor_q ^ byte_s1;
						end else begin
							// check byte
							res.last    = 1'b1;
							phase_d     = PH_HUNT;
							remaining_d = 9'd0;
							xor_d       = 8'h00;
							neg_d       = 1'b0;
							len_d       = 8'h00;
							if (byte_s1 == xor_q) begin
								res.status       = ST_OK;
								res.frame_length = {1'b0, len_q} + FRAME_OVERHEAD;
								attempt_d        = 2'd0;
							end else begin
								res.status = lost_status;
								attempt_d  = lost_attempt;
							end
						end
					end
					default: begin
						// head hunt; exact head or negative form
						if (byte_s1 == expected_head_q) begin
							res_vld = 1'b1;
							neg_d   = 1'b0;
						end else if (expected_head_q[7] &&
								byte_s1 == (expected_head_q - NEG_OFFSET)) begin
							res_vld = 1'b1;
							neg_d   = 1'b1;
						end
						if (res_vld) begin
							xor_d              = byte_s1;
							phase_d            = PH_LEN;
							res.negative_reply = neg_d;
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			remaining_q <= 9'd0;
			xor_q       <= 8'h00;
			attempt_q   <= 2'd0;
			neg_q       <= 1'b0;
			len_q       <= 8'h00;
		end else if (advance_s1) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			xor_q       <= xor_d;
			attempt_q   <= attempt_d;
			neg_q       <= neg_d;
			len_q       <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && res_vld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && res_vld) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_q.attempt, out_q.frame_length, out_q.out_byte};
	assign m_tuser  = {out_q.negative_reply, out_q.status};
	assign m_tlast  = out_q.last;

	// any non-frame status closes the frame or exchange
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] != ST_FRAME) |-> m_tlast)
		else $error("closing status without last");

	// length only reported with ok
	a_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] != ST_OK) |-> (m_tdata[16:8] == 9'd0))
		else $error("frame length on non-ok result");

	// attempt counter never reaches the top code
	a_attempt_range: assert property (@(posedge clk) disable iff (!arst_n)
		attempt_q != 2'd3)
		else $error("attempt counter overflow");

	// a closing result always returns to head hunt
	a_close_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && res_vld && res.last |=> (phase_q == PH_HUNT))
		else $error("no return to hunt after closing result");

endmodule
